FILE: hw/rtl/usm_pkg.sv
// Shared types and constants of the unsharp-mask sharpening block.
// Used by the channel interfaces, the line buffer, the sharpen datapath and the top level.
// No dependencies.
package usm_pkg;

    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int CH_RED     = 2;
    localparam int CH_GREEN   = 1;
    localparam int CH_BLUE    = 0;

    localparam int ROW_W      = 12;
    localparam int OUT_COL_W  = 11;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 13;
    localparam int MAX_ROWS   = 4096;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(2048);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(1);

    // Sum of nine bytes fits in 12 bits; sum * 7282 >> 16 equals sum / 9 over that range.
    localparam int SUM_W        = 12;
    localparam int RECIP_W      = 13;
    localparam int RECIP_SHIFT  = 16;
    localparam logic [RECIP_W-1:0] RECIP_NINE = RECIP_W'(7282);

    typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

    // Three vertically stacked pixels: 0 is two rows back, 1 one row back, 2 the current row.
    typedef pixel_t [2:0] column_t;

    typedef struct packed {
        pixel_t older;
        pixel_t prior;
    } line_pair_t;

endpackage

FILE: hw/rtl/usm_pix_if.sv
// Input pixel channel: valid/ready handshake carrying one RGB pixel.
// Depends on usm_pkg.
interface usm_pix_if;
    logic                      valid;
    logic                      ready;
    logic [usm_pkg::CH_W-1:0]  red_in;
    logic [usm_pkg::CH_W-1:0]  green_in;
    logic [usm_pkg::CH_W-1:0]  blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

FILE: hw/rtl/usm_res_if.sv
// Result channel: valid/ready handshake carrying one sharpened pixel and its position.
// Depends on usm_pkg.
interface usm_res_if;
    logic                           valid;
    logic                           ready;
    logic [usm_pkg::ROW_W-1:0]      out_row;
    logic [usm_pkg::OUT_COL_W-1:0]  out_col;
    logic [usm_pkg::CH_W-1:0]       red_out;
    logic [usm_pkg::CH_W-1:0]       green_out;
    logic [usm_pkg::CH_W-1:0]       blue_out;
    logic                           last_of_run;

    modport source (output valid, output out_row, output out_col, output red_out,
                    output green_out, output blue_out, output last_of_run, input ready);
    modport sink   (input valid, input out_row, input out_col, input red_out,
                    input green_out, input blue_out, input last_of_run, output ready);
endinterface

FILE: hw/rtl/usm_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying a register index and data.
// Depends on usm_pkg.
interface usm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [usm_pkg::CFG_IDX_W-1:0]   index;
    logic [usm_pkg::CFG_DATA_W-1:0]  wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: hw/rtl/unsharp_mask_box_sharpen.sv
// An accepted pixel is held in the input register stage; its results go to the output register.
// Throughput, while the output is not stalled: one pixel per cycle while each pixel causes at most one
// result; a pixel in the last column or the last row causes up to three results, one per cycle.
// Reset: counters and window clear, width 2048, height 1; the line buffers are not cleared.
// Depends on usm_pkg, the three channel interfaces, usm_line_buf and usm_sharpen.
module unsharp_mask_box_sharpen #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    usm_pix_if.sink     pixel,
    usm_res_if.source   result,
    usm_cfg_if.sink     cfg
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int WW     = ADDR_W + 1;

    // Configuration and position counters
    logic [usm_pkg::WIDTH_W-1:0]  width_reg;
    logic [usm_pkg::HEIGHT_W-1:0] height_reg;
    logic [ADDR_W-1:0]            col_reg;
    logic [usm_pkg::ROW_W-1:0]    row_reg;
    logic [WW-1:0]                w_eff;
    logic [usm_pkg::HEIGHT_W-1:0] h_eff;
    logic                         col_last;
    logic                         row_last;
    logic                         cfg_hit;

    // Input register stage
    logic                         s1_valid_reg;
    logic [2:0]                   s1_mask_reg;
    logic [2:0]                   s1_mask_next;
    logic                         s1_sharp_reg;
    logic [usm_pkg::ROW_W-1:0]    s1_row_reg;
    logic [ADDR_W-1:0]            s1_col_reg;
    usm_pkg::pixel_t              s1_pix_reg;
    usm_pkg::column_t             win_left_reg;
    usm_pkg::column_t             win_mid_reg;
    usm_pkg::column_t             cur;
    usm_pkg::line_pair_t          rd_pair;
    usm_pkg::line_pair_t          wr_pair;
    usm_pkg::pixel_t              sharp_px;

    logic [2:0]                   sel;
    logic                         sel_last;
    logic                         slot_free;
    logic                         emit;
    logic                         s1_done;
    logic                         in_fire;

    // Output register
    logic                         out_valid_reg;
    logic [usm_pkg::ROW_W-1:0]    out_row_reg;
    logic [ADDR_W-1:0]            out_col_reg;
    usm_pkg::pixel_t              out_pix_reg;
    logic                         out_last_reg;
    logic [usm_pkg::ROW_W-1:0]    res_row;
    logic [ADDR_W-1:0]            res_col;
    usm_pkg::pixel_t              res_pix;

    assign cfg.ready = 1'b1;
    always_comb
    begin
        unique case (cfg.index)
            usm_pkg::REG_IMAGE_WIDTH:  cfg_hit = cfg.valid;
            usm_pkg::REG_IMAGE_HEIGHT: cfg_hit = cfg.valid;
            default:                   cfg_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_reg);
        end
        if (height_reg == '0)
        begin
            h_eff = usm_pkg::HEIGHT_W'(1);
        end
        else if (32'(height_reg) > usm_pkg::MAX_ROWS)
        begin
            h_eff = usm_pkg::HEIGHT_W'(usm_pkg::MAX_ROWS);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    assign col_last = ({1'b0, col_reg} + WW'(1)) >= w_eff;
    assign row_last = ({1'b0, row_reg} + usm_pkg::HEIGHT_W'(1)) >= h_eff;

    // Results of the held pixel go out lowest flag first: up-left, up, then the pixel itself.
    always_comb
    begin
        if (s1_mask_reg[0])
        begin
            sel = 3'b001;
        end
        else if (s1_mask_reg[1])
        begin
            sel = 3'b010;
        end
        else
        begin
            sel = 3'b100;
        end
    end

    assign sel_last  = (s1_mask_reg & ~sel) == 3'b000;
    assign slot_free = !out_valid_reg || result.ready;
    assign emit      = s1_valid_reg && (s1_mask_reg != 3'b000) && slot_free;
    assign s1_done   = s1_valid_reg && ((s1_mask_reg == 3'b000) || (emit && sel_last));
    assign pixel.ready = !s1_valid_reg || s1_done;
    assign in_fire   = pixel.valid && pixel.ready;
    assign s1_mask_next = s1_mask_reg & ~sel;

    assign cur[0] = rd_pair.older;
    assign cur[1] = rd_pair.prior;
    assign cur[2] = s1_pix_reg;
    assign wr_pair.older = cur[1];
    assign wr_pair.prior = cur[2];

    usm_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .ADDR_W    (ADDR_W)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (col_reg),
        .wr_en   (s1_done),
        .wr_addr (s1_col_reg),
        .wr_data (wr_pair),
        .rd_data (rd_pair)
    );

    usm_sharpen u_sharpen (
        .win_left  (win_left_reg),
        .win_mid   (win_mid_reg),
        .win_right (cur),
        .sharp     (sharp_px)
    );

    always_comb
    begin
        if (sel[0])
        begin
            res_row = s1_row_reg - usm_pkg::ROW_W'(1);
            res_col = s1_col_reg - ADDR_W'(1);
            res_pix = s1_sharp_reg ? sharp_px : win_mid_reg[1];
        end
        else if (sel[1])
        begin
            res_row = s1_row_reg - usm_pkg::ROW_W'(1);
            res_col = s1_col_reg;
            res_pix = cur[1];
        end
        else
        begin
            res_row = s1_row_reg;
            res_col = s1_col_reg;
            res_pix = cur[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= usm_pkg::WIDTH_RESET;
            height_reg    <= usm_pkg::HEIGHT_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s1_mask_reg   <= 3'b000;
            win_left_reg  <= '0;
            win_mid_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                if (col_last)
                begin
                    col_reg <= '0;
                    row_reg <= row_last ? '0 : row_reg + usm_pkg::ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + ADDR_W'(1);
                end
            end

            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
                s1_mask_reg  <= {row_last,
                                 (row_reg != '0) && col_last,
                                 (row_reg != '0) && (col_reg != '0)};
            end
            else if (s1_done)
            begin
                s1_valid_reg <= 1'b0;
                s1_mask_reg  <= 3'b000;
            end
            else if (emit)
            begin
                s1_mask_reg <= s1_mask_next;
            end

            if (s1_done)
            begin
                win_left_reg <= win_mid_reg;
                win_mid_reg  <= cur;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // A register write restarts the frame; the user must write only while the block is idle (not enforced).
            if (cfg_hit)
            begin
                if (cfg.index == usm_pkg::REG_IMAGE_WIDTH)
                begin
                    width_reg <= cfg.wdata[usm_pkg::WIDTH_W-1:0];
                end
                else
                begin
                    height_reg <= cfg.wdata[usm_pkg::HEIGHT_W-1:0];
                end
                col_reg      <= '0;
                row_reg      <= '0;
                win_left_reg <= '0;
                win_mid_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_row_reg   <= row_reg;
            s1_col_reg   <= col_reg;
            s1_sharp_reg <= (row_reg >= usm_pkg::ROW_W'(2)) && (col_reg >= ADDR_W'(2));
            s1_pix_reg   <= {pixel.red_in, pixel.green_in, pixel.blue_in};
        end
        if (emit)
        begin
            out_row_reg  <= res_row;
            out_col_reg  <= res_col;
            out_pix_reg  <= res_pix;
            out_last_reg <= sel_last;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.out_row     = out_row_reg;
    assign result.out_col     = usm_pkg::OUT_COL_W'(out_col_reg);
    assign result.red_out     = out_pix_reg[usm_pkg::CH_RED];
    assign result.green_out   = out_pix_reg[usm_pkg::CH_GREEN];
    assign result.blue_out    = out_pix_reg[usm_pkg::CH_BLUE];
    assign result.last_of_run = out_last_reg;

endmodule

FILE: hw/rtl/usm_line_buf.sv
// Two line buffers (rows two back and one back) held as one memory of paired pixels.
// One write and one registered read per cycle, with write-to-read forwarding. Depends on usm_pkg.
module usm_line_buf #(
    parameter int MAX_WIDTH = 2048,
    parameter int ADDR_W    = 11
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  usm_pkg::line_pair_t  wr_data,
    output usm_pkg::line_pair_t  rd_data
);

    usm_pkg::line_pair_t mem [MAX_WIDTH];
    usm_pkg::line_pair_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            // A one-pixel-wide image reads the entry that is written in the same cycle.
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/usm_sharpen.sv
// Sharpen datapath: 3x3 box sum, divide by nine, wrapped detail and clamped result per channel.
// Depends on usm_pkg.
module usm_sharpen (
    input  usm_pkg::column_t  win_left,
    input  usm_pkg::column_t  win_mid,
    input  usm_pkg::column_t  win_right,
    output usm_pkg::pixel_t   sharp
);

    localparam int PROD_W = usm_pkg::SUM_W + usm_pkg::RECIP_W;

    for (genvar k = 0; k < usm_pkg::NUM_CH; k++)
    begin : g_ch
        logic [usm_pkg::SUM_W-1:0] sum;
        logic [PROD_W-1:0]         prod;
        logic [usm_pkg::CH_W-1:0]  centre;
        logic [usm_pkg::CH_W-1:0]  smooth;
        logic [usm_pkg::CH_W-1:0]  detail;
        logic signed [usm_pkg::CH_W+1:0] value;

        always_comb
        begin
            sum = '0;
            for (int i = 0; i < 3; i++)
            begin
                sum = sum + usm_pkg::SUM_W'(win_left[i][k])
                          + usm_pkg::SUM_W'(win_mid[i][k])
                          + usm_pkg::SUM_W'(win_right[i][k]);
            end
            prod   = PROD_W'(sum) * PROD_W'(usm_pkg::RECIP_NINE);
            smooth = prod[usm_pkg::RECIP_SHIFT +: usm_pkg::CH_W];
            centre = win_mid[1][k];
            // The detail keeps only its low byte and is read back as a signed value.
            detail = centre - smooth;
            value  = $signed({2'b00, centre}) + $signed({{2{detail[usm_pkg::CH_W-1]}}, detail});
            if (value < 0)
            begin
                sharp[k] = '0;
            end
            else if (value > $signed(10'sd255))
            begin
                sharp[k] = '1;
            end
            else
            begin
                sharp[k] = value[usm_pkg::CH_W-1:0];
            end
        end
    end

endmodule

FILE: hw/rtl/usm_checker.sv
// Port-level checks of the sharpening block's result sequencing, bound to the top level.
// Depends on usm_pkg and unsharp_mask_box_sharpen.
module usm_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pix_ready,
    input  logic                           res_valid,
    input  logic                           res_ready,
    input  logic                           res_last,
    input  logic [usm_pkg::ROW_W-1:0]      res_row,
    input  logic [usm_pkg::OUT_COL_W-1:0]  res_col
);

    // A stalled result keeps its position.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_row) && $stable(res_col))
        else $error("stalled result changed its position");

    // When a result that is not the last of its pixel is taken, the next one follows at once.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_last |=> res_valid)
        else $error("results of one pixel did not follow back to back");

    // While a pixel still has results waiting behind a stalled one, no new pixel enters.
    a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready && !res_last |-> !pix_ready)
        else $error("pixel accepted while results of the previous one were pending");

endmodule

bind unsharp_mask_box_sharpen usm_checker u_usm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_ready (pixel.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_last  (result.last_of_run),
    .res_row   (result.out_row),
    .res_col   (result.out_col)
);
